FILE: rtl/core/lcd4_pkg.sv
// ----------------------------------------------------------------------------
// lcd4_pkg
// Shared types, constants and helpers of the 4-bit character LCD core.
// ----------------------------------------------------------------------------
package lcd4_pkg;

    // field and register widths
    localparam int TICK_W   = 20;
    localparam int NIBBLE_W = 4;
    localparam int BYTE_W   = 8;
    localparam int COL_W    = 6;
    localparam int CFG_IDX_W = 2;

    // stream payload widths (padded to whole bytes)
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // default depth of the request queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // register reset values
    localparam logic [TICK_W-1:0] STROBE_HIGH_RST = 20'd400;
    localparam logic [TICK_W-1:0] SETTLE_RST      = 20'd14000;
    localparam logic [TICK_W-1:0] POWER_WAIT_RST  = 20'd500000;
    localparam logic [TICK_W-1:0] WAKE_STROBE_RST = 20'd10000;

    // cursor line bases
    localparam logic [BYTE_W-1:0] LINE0_BASE = 8'h80;
    localparam logic [BYTE_W-1:0] LINE1_BASE = 8'hC0;

    // wake-up strobe nibbles
    localparam logic [NIBBLE_W-1:0] WAKE_NIB   = 4'h3;
    localparam logic [NIBBLE_W-1:0] WAKE_NIB_4 = 4'h2;

    // wake phase: wait/strobe pairs then the final fall
    localparam logic [3:0] WAKE_FIRST_STEP  = 4'd0;
    localparam logic [3:0] WAKE_LAST_STROBE = 4'd7;
    localparam logic [3:0] WAKE_FALL_STEP   = 4'd8;

    // number of set-up instructions after the wake phase, minus one
    localparam logic [2:0] SETUP_LAST_IDX = 3'd4;

    // commands
    typedef enum logic [1:0] {
        CMD_INIT   = 2'd0,
        CMD_CURSOR = 2'd1,
        CMD_DATA   = 2'd2,
        CMD_INSTR  = 2'd3
    } t_cmd;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STROBE_HIGH = 2'd0,
        CFG_SETTLE      = 2'd1,
        CFG_POWER_WAIT  = 2'd2,
        CFG_WAKE_STROBE = 2'd3
    } t_cfg_reg;

    // timing registers handed to the sequencer
    typedef struct packed {
        logic [TICK_W-1:0] strobe_high;
        logic [TICK_W-1:0] settle;
        logic [TICK_W-1:0] power_wait;
        logic [TICK_W-1:0] wake_strobe;
    } t_timing;

    // classified request from the front
    typedef struct packed {
        logic              is_init;
        logic              reg_select;
        logic [BYTE_W-1:0] byte_value;
    } t_job;

    // one pin event
    typedef struct packed {
        logic [NIBBLE_W-1:0] nibble;
        logic                reg_select;
        logic                enable;
        logic [TICK_W-1:0]   hold;
        logic                last;
    } t_event;

    // set-up instruction bytes sent after the wake strobes
    function automatic logic [BYTE_W-1:0] setup_byte(input logic [2:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            3'd0:    b = 8'h28;
            3'd1:    b = 8'h08;
            3'd2:    b = 8'h01;
            3'd3:    b = 8'h06;
            default: b = 8'h0C;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/core/lcd4_front.sv
// ----------------------------------------------------------------------------
// lcd4_front
// Accepts commands and turns them into byte or init requests for the queue.
// ----------------------------------------------------------------------------
module lcd4_front
    import lcd4_pkg::*;
(
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [S_TDATA_W-1:0] i_data,
    input  logic                 i_full,
    output logic                 o_push,
    output t_job                 o_job
);

    t_cmd              cmd;
    logic              row;
    logic [COL_W-1:0]  column;
    logic [BYTE_W-1:0] byte_value;
    logic [BYTE_W-1:0] cursor_byte;

    // unpack the input word
    always_comb begin
        cmd        = t_cmd'(i_data[1:0]);
        row        = i_data[2];
        column     = i_data[8:3];
        byte_value = i_data[16:9];
    end

    // cursor address: line base plus column
    assign cursor_byte = (row ? LINE1_BASE : LINE0_BASE) + {2'b00, column};

    // handshake
    assign o_ready = ~i_full;
    assign o_push  = i_valid & ~i_full;

    // classify the command
    always_comb begin
        o_job = '0;
        unique case (cmd)
            CMD_INIT: begin
                o_job.is_init = 1'b1;
            end
            CMD_CURSOR: begin
                o_job.byte_value = cursor_byte;
            end
            CMD_DATA: begin
                o_job.reg_select = 1'b1;
                o_job.byte_value = byte_value;
            end
            default: begin
                o_job.byte_value = byte_value;
            end
        endcase
    end

endmodule

FILE: rtl/core/lcd4_queue.sv
// ----------------------------------------------------------------------------
// lcd4_queue
// Small request queue between the front and the event sequencer.
// ----------------------------------------------------------------------------
module lcd4_queue
    import lcd4_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: rtl/core/lcd4_back.sv
// ----------------------------------------------------------------------------
// lcd4_back
// Event sequencer: turns a request into pin events, one per unstalled cycle.
// ----------------------------------------------------------------------------
module lcd4_back
    import lcd4_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_timing i_timing,
    input  logic    i_job_valid,
    input  t_job    i_job,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_event  o_event
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WAKE = 3'b010,
        ST_BYTE = 3'b100
    } t_back_state;

    t_back_state       r_state, n_state;
    logic              r_is_init, n_is_init;
    logic              r_sel, n_sel;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic [3:0]        r_step, n_step;
    logic [2:0]        r_idx, n_idx;
    logic [1:0]        r_sub, n_sub;
    logic              r_out_valid, n_out_valid;
    t_event            r_out;

    t_event            cur;
    logic [BYTE_W-1:0] cur_byte;
    logic              advance;
    logic              load;

    // event for the current step
    always_comb begin
        cur      = '0;
        cur_byte = r_is_init ? setup_byte(r_idx) : r_byte;
        unique case (r_state)
            ST_WAKE: begin
                if (r_step == WAKE_FALL_STEP) begin
                    cur.nibble = WAKE_NIB_4;
                end else if (!r_step[0]) begin
                    // power wait with the previous nibble held
                    cur.nibble = (r_step == WAKE_FIRST_STEP) ? '0 : WAKE_NIB;
                    cur.hold   = i_timing.power_wait;
                end else begin
                    cur.nibble = (r_step == WAKE_LAST_STROBE) ? WAKE_NIB_4 : WAKE_NIB;
                    cur.enable = 1'b1;
                    cur.hold   = i_timing.wake_strobe;
                end
            end
            ST_BYTE: begin
                cur.nibble     = r_sub[1] ? cur_byte[3:0] : cur_byte[7:4];
                cur.reg_select = r_sel;
                cur.enable     = ~r_sub[0];
                cur.hold       = r_sub[0] ? i_timing.settle : i_timing.strobe_high;
                cur.last       = (r_sub == 2'd3) && (!r_is_init || r_idx == SETUP_LAST_IDX);
            end
            default: begin
                cur = '0;
            end
        endcase
    end

    // step when the output register is free or being drained
    assign advance = (r_state != ST_IDLE) && (!r_out_valid || i_ready);
    assign load    = i_job_valid && ((r_state == ST_IDLE) || (advance && cur.last));
    assign o_pop   = load;

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_is_init   = r_is_init;
        n_sel       = r_sel;
        n_byte      = r_byte;
        n_step      = r_step;
        n_idx       = r_idx;
        n_sub       = r_sub;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (advance) begin
            n_out_valid = 1'b1;
        end

        unique case (r_state)
            ST_WAKE: begin
                if (advance) begin
                    if (r_step == WAKE_FALL_STEP) begin
                        n_state = ST_BYTE;
                        n_idx   = '0;
                        n_sub   = '0;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            ST_BYTE: begin
                if (advance) begin
                    if (cur.last) begin
                        n_state = ST_IDLE;
                    end else if (r_sub == 2'd3) begin
                        n_idx = r_idx + 1'b1;
                        n_sub = '0;
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // take the next request
        if (load) begin
            n_state   = i_job.is_init ? ST_WAKE : ST_BYTE;
            n_is_init = i_job.is_init;
            n_sel     = i_job.reg_select;
            n_byte    = i_job.byte_value;
            n_step    = '0;
            n_idx     = '0;
            n_sub     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_idx       <= '0;
            r_sub       <= '0;
            r_is_init   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_idx       <= n_idx;
            r_sub       <= n_sub;
            r_is_init   <= n_is_init;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sel  <= n_sel;
        r_byte <= n_byte;
        if (advance) begin
            r_out <= cur;
        end
    end

    assign o_valid = r_out_valid;
    assign o_event = r_out;

endmodule

FILE: rtl/core/char_lcd_4bit_interface_core.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface_core
// Character LCD controller for a 4-bit bus, emitting timed pin events.
// ----------------------------------------------------------------------------
// Each command becomes a stream of pin events (D7..D4, RS, E, hold ticks),
// the last one flagged by tlast. Byte commands (set cursor, data, instruction)
// give 4 events, the init command 29. The event sequencer produces one event
// per clock while the output side is ready; the next command is taken
// from the request queue in the same cycle its predecessor's final event
// is registered. Commands are accepted whenever the queue (QUEUE_DEPTH
// entries) has room. The output register holds each event until it is
// taken; while an event waits there the sequencer stalls, and a new event
// is registered in the cycle the waiting one is taken.
// The user must write the timing registers through the cfg port only while
// the core is idle; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module char_lcd_4bit_interface_core
    import lcd4_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // command[1:0], row[2], column[8:3], byte_value[16:9], zero pad[23:17]
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // pin event stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // data_nibble[3:0], enable_level[4], hold_ticks[24:5], zero pad[31:25]
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // reg_select[0]
    output logic                 o_m_axis_tuser,
    output logic                 o_m_axis_tlast,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TICK_W-1:0]    i_cfg_data
);

    t_timing r_timing;
    logic    front_push;
    t_job    front_job;
    logic    q_full;
    logic    q_valid;
    t_job    q_job;
    logic    back_pop;
    t_event  back_event;

    // timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.strobe_high <= STROBE_HIGH_RST;
            r_timing.settle      <= SETTLE_RST;
            r_timing.power_wait  <= POWER_WAIT_RST;
            r_timing.wake_strobe <= WAKE_STROBE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_STROBE_HIGH: r_timing.strobe_high <= i_cfg_data;
                CFG_SETTLE:      r_timing.settle      <= i_cfg_data;
                CFG_POWER_WAIT:  r_timing.power_wait  <= i_cfg_data;
                default:         r_timing.wake_strobe <= i_cfg_data;
            endcase
        end
    end

    // command intake
    lcd4_front u_front (
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_full  (q_full),
        .o_push  (front_push),
        .o_job   (front_job)
    );

    // request queue
    lcd4_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // event sequencer
    lcd4_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_timing    (r_timing),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (back_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_event     (back_event)
    );

    // pack the output stream
    assign o_m_axis_tdata = {7'd0, back_event.hold, back_event.enable, back_event.nibble};
    assign o_m_axis_tuser = back_event.reg_select;
    assign o_m_axis_tlast = back_event.last;

endmodule
